// ----- rtl/fba_pkg.sv -----
// ----------------------------------------------------------------------------
// fba_pkg
// Shared types and constants of the frame bitmap allocator.
// ----------------------------------------------------------------------------
package fba_pkg;

  localparam int MAX_FRAMES_DEF    = 4096;
  localparam int WORD_BITS_DEF     = 32;
  localparam int FRAME_FIELD_LIMIT = 4096;
  localparam int GROUP_WORDS       = 16;

  localparam int FRAME_W = 12;
  localparam int CFG_W   = 13;
  localparam int STAT_W  = 2;

  localparam logic [CFG_W-1:0] FRAME_COUNT_RESET = 13'd4096;

  localparam logic ACT_ALLOC = 1'b0;
  localparam logic ACT_FREE  = 1'b1;

  localparam logic [STAT_W-1:0] ST_DONE = 2'd0;
  localparam logic [STAT_W-1:0] ST_SKIP = 2'd1;
  localparam logic [STAT_W-1:0] ST_FULL = 2'd2;

  typedef struct packed {
    logic               action;
    logic [FRAME_W-1:0] current_frame;
    logic               kernel_page;
    logic               page_writable;
  } req_t;

  typedef struct packed {
    logic [FRAME_W-1:0] frame_index;
    logic               present;
    logic               writable;
    logic               user_mode;
    logic [STAT_W-1:0]  status;
  } res_t;

endpackage

// ----- rtl/fba_bitmap.sv -----
// ----------------------------------------------------------------------------
// fba_bitmap
// Frame bitmap store: one synchronous word memory with a registered read,
// per-word valid bits so that unwritten words read as all free, and a
// per-word full flag kept in step with every write.
// ----------------------------------------------------------------------------
module fba_bitmap import fba_pkg::*; #(
  parameter int WORDS     = 128,
  parameter int WORD_BITS = WORD_BITS_DEF,
  parameter int AW        = 7
) (
  input  logic                 clk,
  input  logic                 rst,
  input  logic                 rd_en,
  input  logic [AW-1:0]        rd_addr,
  input  logic                 wr_en,
  input  logic [AW-1:0]        wr_addr,
  input  logic [WORD_BITS-1:0] wr_data,
  output logic [WORD_BITS-1:0] rd_word,
  output logic [WORDS-1:0]     full
);

  logic [WORD_BITS-1:0] mem [WORDS];
  logic [WORDS-1:0]     valid;
  logic [WORD_BITS-1:0] rd_data;
  logic                 rd_hit;

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
    if (rd_en) begin
      rd_data <= mem[rd_addr];
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      valid  <= '0;
      full   <= '0;
      rd_hit <= 1'b0;
    end else begin
      if (wr_en) begin
        valid[wr_addr] <= 1'b1;
        full[wr_addr]  <= (wr_data == {WORD_BITS{1'b1}});
      end
      if (rd_en) begin
        rd_hit <= valid[rd_addr];
      end
    end
  end

  assign rd_word = rd_hit ? rd_data : '0;

endmodule

// ----- rtl/frame_bitmap_allocator_core.sv -----
// ----------------------------------------------------------------------------
// frame_bitmap_allocator_core
// First-fit page frame allocator over a bitmap of physical frames.
// ----------------------------------------------------------------------------
// A request is taken on start while busy is low. An allocate request with a
// zero frame field gets the lowest free frame among the first frame_count
// frames, rounded down to whole words and capped at 4096; a free request
// clears the bit of its frame. Every request gives exactly one result on
// result, marked by done for one cycle. Skipped allocates, frees of frame
// zero and frees beyond the store answer in the cycle after the request.
// A free of a stored frame does one memory read, then the write back. An
// allocate does a group pick over the full-word summary, a word pick that
// issues the memory read, then the bit search and write back. An allocate
// that finds no free frame answers at the group pick. The single memory
// read port sets this sequence; busy stays high until the result is
// produced, and busy is low in the cycle that done is high, so a new
// request may be taken then. The receiver cannot stall.
// Reset marks every frame free at once and sets frame_count to 4096.
// cfg_write loads frame_count from cfg_data and must only be used while
// no request is in progress.
// ----------------------------------------------------------------------------
module frame_bitmap_allocator_core import fba_pkg::*; #(
  parameter int MAX_FRAMES = MAX_FRAMES_DEF,
  parameter int WORD_BITS  = WORD_BITS_DEF
) (
  input  logic             clk,
  input  logic             rst,
  input  logic             start,
  output logic             busy,
  input  req_t             req,
  input  logic             cfg_write,
  input  logic [CFG_W-1:0] cfg_data,
  output logic             done,
  output res_t             result
);

  localparam int WORD_COUNT = MAX_FRAMES / WORD_BITS;
  localparam int NGRP       = (WORD_COUNT + GROUP_WORDS - 1) / GROUP_WORDS;
  localparam int PADW       = NGRP * GROUP_WORDS;
  localparam int WIDX_W     = $clog2(PADW);
  localparam int GIDX_W     = (NGRP > 1) ? $clog2(NGRP) : 1;
  localparam int SUB_W      = $clog2(GROUP_WORDS);
  localparam int BIT_W      = $clog2(WORD_BITS);
  localparam int LIMIT      = (MAX_FRAMES < FRAME_FIELD_LIMIT) ? MAX_FRAMES
                                                              : FRAME_FIELD_LIMIT;

  typedef enum logic [3:0] {
    S_IDLE = 4'b0001,
    S_GSEL = 4'b0010,
    S_WSEL = 4'b0100,
    S_MOD  = 4'b1000
  } state_t;

  state_t               state;
  logic [CFG_W-1:0]     frame_count;
  logic                 op_free;
  logic                 kernel;
  logic                 wr_flag;
  logic [GIDX_W-1:0]    grp;
  logic [WIDX_W-1:0]    waddr;
  logic [BIT_W-1:0]     bsel;

  logic                 rd_en;
  logic [WIDX_W-1:0]    rd_addr;
  logic                 wr_en;
  logic [WORD_BITS-1:0] wr_data;
  logic [WORD_BITS-1:0] rd_word;
  logic [PADW-1:0]      full;

  logic [CFG_W-1:0]     cnt_cap;
  logic [CFG_W-1:0]     words;
  logic [PADW-1:0]      elig;
  logic [NGRP-1:0]      gany;
  logic [GROUP_WORDS-1:0] gbits;
  logic [SUB_W-1:0]     sub_sel;
  logic [BIT_W-1:0]     zbit;
  logic                 accept;
  logic                 free_in_range;
  logic [WIDX_W-1:0]    free_word;

  function automatic logic [GIDX_W-1:0] pick_group(input logic [NGRP-1:0] v);
    logic [GIDX_W-1:0] idx;
    idx = '0;
    for (int i = NGRP - 1; i >= 0; i--) begin
      if (v[i]) idx = GIDX_W'(i);
    end
    return idx;
  endfunction

  function automatic logic [SUB_W-1:0] pick_word(input logic [GROUP_WORDS-1:0] v);
    logic [SUB_W-1:0] idx;
    idx = '0;
    for (int i = GROUP_WORDS - 1; i >= 0; i--) begin
      if (v[i]) idx = SUB_W'(i);
    end
    return idx;
  endfunction

  function automatic logic [BIT_W-1:0] pick_zero(input logic [WORD_BITS-1:0] v);
    logic [BIT_W-1:0] idx;
    idx = '0;
    for (int i = WORD_BITS - 1; i >= 0; i--) begin
      if (!v[i]) idx = BIT_W'(i);
    end
    return idx;
  endfunction

  assign cnt_cap = (frame_count > CFG_W'(LIMIT)) ? CFG_W'(LIMIT) : frame_count;
  assign words   = cnt_cap >> BIT_W;

  for (genvar w = 0; w < PADW; w++) begin : g_elig
    assign elig[w] = !full[w] && (words > CFG_W'(w));
  end

  for (genvar g = 0; g < NGRP; g++) begin : g_any
    assign gany[g] = |elig[g*GROUP_WORDS +: GROUP_WORDS];
  end

  assign gbits   = elig[grp*GROUP_WORDS +: GROUP_WORDS];
  assign sub_sel = pick_word(gbits);
  assign zbit    = pick_zero(rd_word);

  assign busy          = (state != S_IDLE);
  assign accept        = start && (state == S_IDLE);
  assign free_in_range = (32'(req.current_frame) < 32'(MAX_FRAMES)) &&
                         (32'(req.current_frame >> BIT_W) < 32'(WORD_COUNT));
  assign free_word     = WIDX_W'(req.current_frame >> BIT_W);

  always_comb begin
    rd_en   = 1'b0;
    rd_addr = free_word;
    if (accept && req.action == ACT_FREE && req.current_frame != '0 && free_in_range) begin
      rd_en = 1'b1;
    end else if (state == S_WSEL) begin
      rd_en   = 1'b1;
      rd_addr = WIDX_W'({grp, sub_sel});
    end
  end

  assign wr_en   = (state == S_MOD);
  assign wr_data = op_free ? (rd_word & ~(WORD_BITS'(1) << bsel))
                           : (rd_word | (WORD_BITS'(1) << zbit));

  fba_bitmap #(
    .WORDS     (PADW),
    .WORD_BITS (WORD_BITS),
    .AW        (WIDX_W)
  ) u_bitmap (
    .clk     (clk),
    .rst     (rst),
    .rd_en   (rd_en),
    .rd_addr (rd_addr),
    .wr_en   (wr_en),
    .wr_addr (waddr),
    .wr_data (wr_data),
    .rd_word (rd_word),
    .full    (full)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      state       <= S_IDLE;
      frame_count <= FRAME_COUNT_RESET;
      done        <= 1'b0;
    end else begin
      done <= 1'b0;
      if (cfg_write) begin
        frame_count <= cfg_data;
      end
      unique case (state)
        S_IDLE: begin
          if (accept) begin
            if (req.action == ACT_FREE) begin
              if (req.current_frame == '0) begin
                done   <= 1'b1;
                result <= '{frame_index: '0, present: 1'b0, writable: 1'b0,
                            user_mode: 1'b0, status: ST_SKIP};
              end else if (free_in_range) begin
                op_free <= 1'b1;
                bsel    <= req.current_frame[BIT_W-1:0];
                state   <= S_MOD;
              end else begin
                done   <= 1'b1;
                result <= '{frame_index: '0, present: 1'b0, writable: 1'b0,
                            user_mode: 1'b0, status: ST_DONE};
              end
            end else if (req.current_frame != '0) begin
              done   <= 1'b1;
              result <= '{frame_index: req.current_frame, present: 1'b0,
                          writable: 1'b0, user_mode: 1'b0, status: ST_SKIP};
            end else begin
              op_free <= 1'b0;
              kernel  <= req.kernel_page;
              wr_flag <= req.page_writable;
              state   <= S_GSEL;
            end
          end
        end
        S_GSEL: begin
          if (gany == '0) begin
            done   <= 1'b1;
            result <= '{frame_index: '0, present: 1'b0, writable: 1'b0,
                        user_mode: 1'b0, status: ST_FULL};
            state  <= S_IDLE;
          end else begin
            grp   <= pick_group(gany);
            state <= S_WSEL;
          end
        end
        S_WSEL: begin
          state <= S_MOD;
        end
        S_MOD: begin
          done <= 1'b1;
          if (op_free) begin
            result <= '{frame_index: '0, present: 1'b0, writable: 1'b0,
                        user_mode: 1'b0, status: ST_DONE};
          end else begin
            result <= '{frame_index: FRAME_W'({waddr, zbit}), present: 1'b1,
                        writable: wr_flag, user_mode: !kernel, status: ST_DONE};
          end
          state <= S_IDLE;
        end
        default: begin
          state <= S_IDLE;
        end
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (rd_en) begin
      waddr <= rd_addr;
    end
  end

endmodule

// ----- tb/tb_frame_bitmap_allocator_core.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_frame_bitmap_allocator_core
// Self-checking bench for the first-fit frame bitmap allocator.
// ----------------------------------------------------------------------------
// The bench keeps its own copy of the frame bitmap and frame count. It uses
// that copy to work out the result of every accepted request and compares
// each result field by field, in order. Directed tests cover reset, skipped
// allocates, frees and the limits of the frame count. Random phases then mix
// allocates, frees, skipped allocates and stray frees under several frame
// counts, with random gaps between requests.
// ----------------------------------------------------------------------------
module tb_frame_bitmap_allocator_core;
  import fba_pkg::*;

  localparam int CYCLE_LIMIT = 400000;

  logic             clk = 1'b0;
  logic             rst = 1'b1;
  logic             start = 1'b0;
  logic             busy;
  req_t             req = '0;
  logic             cfg_write = 1'b0;
  logic [CFG_W-1:0] cfg_data = '0;
  logic             done;
  res_t             result;

  logic [MAX_FRAMES_DEF-1:0] frame_in_use = '0;
  logic [CFG_W-1:0]          frame_limit = FRAME_COUNT_RESET;
  res_t                      pending_results[$];
  int                        owned_frames[$];
  int                        error_count = 0;
  int unsigned               cycle_count = 0;
  bit                        gaps_on = 1'b1;

  frame_bitmap_allocator_core i_dut (
    .clk       (clk),
    .rst       (rst),
    .start     (start),
    .busy      (busy),
    .req       (req),
    .cfg_write (cfg_write),
    .cfg_data  (cfg_data),
    .done      (done),
    .result    (result)
  );

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count == CYCLE_LIMIT) begin
      $display("status: fail");
      $finish;
    end
  end

  function automatic req_t make_req(input logic act, input int frame, input logic kern,
                                    input logic wr);
    req_t r;
    r.action        = act;
    r.current_frame = FRAME_W'(frame);
    r.kernel_page   = kern;
    r.page_writable = wr;
    return r;
  endfunction

  // Updates the local bitmap for one request and returns its result.
  function automatic res_t allocate_or_free(input req_t r);
    res_t o;
    int   words;
    o = '0;
    if (r.action == ACT_FREE) begin
      if (r.current_frame == '0) begin
        o.status = ST_SKIP;
      end else begin
        frame_in_use[r.current_frame] = 1'b0;
        o.status = ST_DONE;
      end
    end else if (r.current_frame != '0) begin
      o.frame_index = r.current_frame;
      o.status      = ST_SKIP;
    end else begin
      words = (frame_limit > FRAME_FIELD_LIMIT) ? FRAME_FIELD_LIMIT : int'(frame_limit);
      words = words / WORD_BITS_DEF;
      o.status = ST_FULL;
      for (int f = 0; f < words * WORD_BITS_DEF; f++) begin
        if (!frame_in_use[f]) begin
          frame_in_use[f] = 1'b1;
          o.frame_index   = FRAME_W'(f);
          o.present       = 1'b1;
          o.writable      = r.page_writable;
          o.user_mode     = !r.kernel_page;
          o.status        = ST_DONE;
          break;
        end
      end
    end
    return o;
  endfunction

  task automatic send_request(input req_t r);
    int   gap;
    res_t predicted;
    gap = gaps_on ? $urandom_range(0, 13) : 0;
    if (gap > 0) begin
      start <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    start <= 1'b1;
    req   <= r;
    @(posedge clk);
    while (busy) @(posedge clk);
    predicted = allocate_or_free(r);
    pending_results.push_back(predicted);
    if (r.action == ACT_ALLOC && predicted.present) begin
      owned_frames.push_back(int'(predicted.frame_index));
    end
  endtask

  task automatic wait_idle();
    start <= 1'b0;
    while (pending_results.size() != 0) @(posedge clk);
    while (busy) @(posedge clk);
  endtask

  task automatic set_frame_count(input logic [CFG_W-1:0] value);
    wait_idle();
    cfg_write <= 1'b1;
    cfg_data  <= value;
    @(posedge clk);
    cfg_write <= 1'b0;
    frame_limit = value;
  endtask

  always @(posedge clk) begin
    res_t want;
    if (!rst && done) begin
      if (pending_results.size() == 0) begin
        $display("%0t: unexpected result %h", $time, result);
        error_count++;
      end else begin
        want = pending_results.pop_front();
        if (result.frame_index !== want.frame_index) begin
          $display("%0t: frame_index expected %0d actual %0d", $time, want.frame_index,
                   result.frame_index);
          error_count++;
        end
        if (result.present !== want.present) begin
          $display("%0t: present expected %0d actual %0d", $time, want.present,
                   result.present);
          error_count++;
        end
        if (result.writable !== want.writable) begin
          $display("%0t: writable expected %0d actual %0d", $time, want.writable,
                   result.writable);
          error_count++;
        end
        if (result.user_mode !== want.user_mode) begin
          $display("%0t: user_mode expected %0d actual %0d", $time, want.user_mode,
                   result.user_mode);
          error_count++;
        end
        if (result.status !== want.status) begin
          $display("%0t: status expected %0d actual %0d", $time, want.status,
                   result.status);
          error_count++;
        end
      end
    end
  end

  // Frame zero is handed out first after reset, like any other frame.
  task automatic test_first_fit_after_reset();
    send_request(make_req(ACT_ALLOC, 0, 1'b0, 1'b0));
    send_request(make_req(ACT_ALLOC, 0, 1'b0, 1'b1));
    send_request(make_req(ACT_ALLOC, 0, 1'b1, 1'b0));
    send_request(make_req(ACT_ALLOC, 0, 1'b1, 1'b1));
  endtask

  task automatic test_allocate_skipped();
    send_request(make_req(ACT_ALLOC, 1, 1'b1, 1'b1));
    send_request(make_req(ACT_ALLOC, 4095, 1'b0, 1'b1));
    send_request(make_req(ACT_ALLOC, 'h555, 1'b1, 1'b0));
    send_request(make_req(ACT_ALLOC, 'hAAA, 1'b0, 1'b0));
  endtask

  task automatic test_free_requests();
    send_request(make_req(ACT_FREE, 0, 1'b1, 1'b1));
    send_request(make_req(ACT_FREE, 4095, 1'b0, 1'b1));
    send_request(make_req(ACT_FREE, 2, 1'b1, 1'b0));
    send_request(make_req(ACT_ALLOC, 0, 1'b0, 1'b1));
  endtask

  // A count below one word leaves nothing to allocate; counts above 4096 are clipped.
  task automatic test_frame_count_limits();
    set_frame_count(13'd31);
    send_request(make_req(ACT_ALLOC, 0, 1'b0, 1'b1));
    set_frame_count(13'd0);
    send_request(make_req(ACT_ALLOC, 0, 1'b1, 1'b1));
    set_frame_count(13'd8191);
    send_request(make_req(ACT_ALLOC, 0, 1'b1, 1'b0));
    set_frame_count(13'd32);
    send_request(make_req(ACT_ALLOC, 0, 1'b0, 1'b0));
  endtask

  task automatic test_random_traffic(input logic [CFG_W-1:0] limit, input int count);
    req_t r;
    int   pick;
    int   slot;
    set_frame_count(limit);
    gaps_on = ($urandom_range(0, 3) != 0);
    for (int n = 0; n < count; n++) begin
      if ($urandom_range(0, 19) == 0) gaps_on = !gaps_on;
      pick = $urandom_range(0, 99);
      r = make_req(ACT_ALLOC, 0, 1'($urandom_range(0, 1)), 1'($urandom_range(0, 1)));
      if (pick >= 55 && pick < 85 && owned_frames.size() != 0) begin
        slot = $urandom_range(0, owned_frames.size() - 1);
        r.action        = ACT_FREE;
        r.current_frame = FRAME_W'(owned_frames[slot]);
        owned_frames.delete(slot);
      end else if (pick >= 85 && pick < 93) begin
        r.current_frame = FRAME_W'($urandom_range(1, 4095));
      end else if (pick >= 93) begin
        r.action        = ACT_FREE;
        r.current_frame = FRAME_W'($urandom_range(0, 4095));
      end
      send_request(r);
    end
  endtask

  initial begin
    repeat (12) @(posedge clk);
    rst <= 1'b0;
    test_first_fit_after_reset();
    test_allocate_skipped();
    test_free_requests();
    test_frame_count_limits();
    test_random_traffic(13'd4096, 160);
    test_random_traffic(13'd32, 110);
    test_random_traffic(13'd64, 110);
    test_random_traffic(13'd8191, 110);
    test_random_traffic(CFG_W'($urandom_range(1, 128) * 32), 110);
    test_random_traffic(CFG_W'($urandom_range(0, 8191)), 110);
    wait_idle();
    repeat (8) @(posedge clk);
    if (error_count == 0) begin
      $display("status: pass");
    end else begin
      $display("status: fail");
    end
    $finish;
  end

endmodule
